/* sv/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int HEADER_BYTES_DEF = 16;
   localparam int MAX_BLOCKS_DEF   = 256;
   localparam logic [31:0] HEAP_BYTES_RESET = 32'(1024 * 1024 * 32);

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_INIT    = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOFIT    = 3'd1,
      ST_ZERO     = 3'd2,
      ST_NOTALLOC = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_BOOT, S_IDLE, S_INIT,
      S_A_RD, S_A_CHK, S_A_SCAN, S_A_WRN, S_A_WRS, S_A_WRA,
      S_R_RD, S_R_CHK, S_R_P, S_R_PM, S_R_PL, S_R_N, S_R_NM, S_R_NL
   } state_type;

   typedef struct packed {
      logic [31:0] offset;
      logic [31:0] size;
      logic        used;
   } info_type;

endpackage

/* sv/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with split and coalescing over an address-ordered
// block list held in two single-port synchronous memories.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result shows
// on the rsp_ ports for exactly one cycle, marked by rsp_valid, and the
// receiver cannot stall it. One transaction is worked on at a time. Allocate
// walks the list, reading and then checking each block it visits; a split
// adds a search for a spare header slot, one slot per cycle across up to
// MAX_BLOCKS slots, then writes the remainder header, the shortened block
// and, if there is a successor, its back link. Release walks the list to
// find the address, then merges with a free predecessor and successor. An
// allocate of zero bytes and the unknown opcode are answered from idle;
// initialise rebuilds the single free block. The list walk, one header per
// read, sets the cost. After reset the block is busy while it builds the
// single free block. heap_ff is sampled at boot and initialise only.
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_release_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_granted_address,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int SW = $clog2(MAX_BLOCKS + 1);
   localparam logic [SW-1:0] NULL_SLOT = SW'(MAX_BLOCKS);
   localparam logic [33:0] HDR = 34'(HEADER_BYTES);
   localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_BLOCKS - 1);

   // Header memories: offset/size/used flag and next/prev links.
   info_type          info_mem [MAX_BLOCKS];
   logic [2*SW-1:0]   link_mem [MAX_BLOCKS];
   info_type          info_rd_ff;
   logic [2*SW-1:0]   link_rd_ff;

   state_type         state_ff, state_in;
   logic [31:0]       heap_ff;
   logic [31:0]       req_ff, req_in;
   logic [31:0]       addr_ff, addr_in;
   logic [SW-1:0]     s_ff, s_in;
   info_type          cur_info_ff, cur_info_in;
   logic [SW-1:0]     cur_next_ff, cur_next_in;
   logic [SW-1:0]     cur_prev_ff, cur_prev_in;
   logic [SW-1:0]     n_ff, n_in;
   logic [SW-1:0]     after_ff, after_in;
   logic [IW-1:0]     scan_ff, scan_in;
   logic [MAX_BLOCKS-1:0] live_ff, live_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_grant_ff, rsp_grant_in;
   status_type        rsp_status_ff, rsp_status_in;

   // Memory port controls.
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic              info_we_off, info_we_size, info_we_used;
   logic [IW-1:0]     info_waddr;
   info_type          info_wdata;
   logic              link_we_next, link_we_prev;
   logic [IW-1:0]     link_waddr;
   logic [SW-1:0]     link_wnext, link_wprev;

   logic [32:0]       need;
   logic [33:0]       need34, need_hdr, sz34;
   logic [SW-1:0]     rd_next, rd_prev;
   logic [IW-1:0]     s_idx;
   logic [31:0]       grant;
   logic [31:0]       sum_size;

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_grant_ff;
   assign rsp_status          = rsp_status_ff;

   always_comb begin
      need     = {1'b0, req_ff} + HDR[32:0];
      need34   = {1'b0, need};
      need_hdr = need34 + HDR;
      sz34     = {2'b00, info_rd_ff.size};
      rd_next  = link_rd_ff[2*SW-1:SW];
      rd_prev  = link_rd_ff[SW-1:0];
      s_idx    = s_ff[IW-1:0];
      grant    = cur_info_ff.offset + 32'(HEADER_BYTES);
      sum_size = info_rd_ff.size + cur_info_ff.size;

      state_in      = state_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      s_in          = s_ff;
      cur_info_in   = cur_info_ff;
      cur_next_in   = cur_next_ff;
      cur_prev_in   = cur_prev_ff;
      n_in          = n_ff;
      after_in      = after_ff;
      scan_in       = scan_ff;
      live_in       = live_ff;
      rsp_valid_in  = 1'b0;
      rsp_grant_in  = '0;
      rsp_status_in = ST_OK;

      rd_en        = 1'b0;
      rd_addr      = s_idx;
      info_we_off  = 1'b0;
      info_we_size = 1'b0;
      info_we_used = 1'b0;
      info_waddr   = s_idx;
      info_wdata   = cur_info_ff;
      link_we_next = 1'b0;
      link_we_prev = 1'b0;
      link_waddr   = s_idx;
      link_wnext   = NULL_SLOT;
      link_wprev   = NULL_SLOT;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in  = req_request_bytes;
               addr_in = req_release_address;
               s_in    = '0;
               case (opcode_type'(req_opcode))
                  OP_ALLOC: begin
                     if (req_request_bytes == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_ZERO;
                     end else begin
                        state_in = S_A_RD;
                     end
                  end
                  OP_RELEASE: state_in = S_R_RD;
                  OP_INIT:    state_in = S_INIT;
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_BOOT, S_INIT: begin
            // Build one free block at slot zero covering the heap.
            info_we_off  = 1'b1;
            info_we_size = 1'b1;
            info_we_used = 1'b1;
            info_waddr   = '0;
            info_wdata   = '{offset: 32'd0, size: heap_ff, used: 1'b0};
            link_we_next = 1'b1;
            link_we_prev = 1'b1;
            link_waddr   = '0;
            live_in      = '0;
            live_in[0]   = 1'b1;
            rsp_valid_in = (state_ff == S_INIT);
            state_in     = S_IDLE;
         end
         S_A_RD: begin
            if (s_ff < NULL_SLOT && live_ff[s_idx]) begin
               rd_en    = 1'b1;
               state_in = S_A_CHK;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOFIT;
               state_in      = S_IDLE;
            end
         end
         S_A_CHK: begin
            cur_info_in = info_rd_ff;
            cur_next_in = rd_next;
            if (!info_rd_ff.used && sz34 > need34) begin
               if (sz34 <= need_hdr) begin
                  // Take the whole block.
                  info_we_used    = 1'b1;
                  info_wdata.used = 1'b1;
                  rsp_valid_in    = 1'b1;
                  rsp_grant_in    = info_rd_ff.offset + 32'(HEADER_BYTES);
                  state_in        = S_IDLE;
               end else begin
                  scan_in  = '0;
                  state_in = S_A_SCAN;
               end
            end else begin
               s_in     = rd_next;
               state_in = S_A_RD;
            end
         end
         S_A_SCAN: begin
            if (!live_ff[scan_ff]) begin
               n_in     = SW'(scan_ff);
               state_in = S_A_WRN;
            end else if (scan_ff == LAST_SLOT) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               state_in      = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_A_WRN: begin
            // Write the free remainder header.
            info_we_off  = 1'b1;
            info_we_size = 1'b1;
            info_we_used = 1'b1;
            info_waddr   = n_ff[IW-1:0];
            info_wdata   = '{offset: cur_info_ff.offset + need[31:0],
                             size:   cur_info_ff.size - need[31:0],
                             used:   1'b0};
            link_we_next = 1'b1;
            link_we_prev = 1'b1;
            link_waddr   = n_ff[IW-1:0];
            link_wnext   = cur_next_ff;
            link_wprev   = s_ff;
            live_in[n_ff[IW-1:0]] = 1'b1;
            state_in     = S_A_WRS;
         end
         S_A_WRS: begin
            info_we_size    = 1'b1;
            info_we_used    = 1'b1;
            info_wdata.size = need[31:0];
            info_wdata.used = 1'b1;
            link_we_next    = 1'b1;
            link_wnext      = n_ff;
            if (cur_next_ff < NULL_SLOT) begin
               state_in = S_A_WRA;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_grant_in = grant;
               state_in     = S_IDLE;
            end
         end
         S_A_WRA: begin
            link_we_prev = 1'b1;
            link_waddr   = cur_next_ff[IW-1:0];
            link_wprev   = n_ff;
            rsp_valid_in = 1'b1;
            rsp_grant_in = grant;
            state_in     = S_IDLE;
         end
         S_R_RD: begin
            if (s_ff < NULL_SLOT && live_ff[s_idx]) begin
               rd_en    = 1'b1;
               state_in = S_R_CHK;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOTALLOC;
               state_in      = S_IDLE;
            end
         end
         S_R_CHK: begin
            cur_info_in = info_rd_ff;
            cur_next_in = rd_next;
            cur_prev_in = rd_prev;
            if ({1'b0, info_rd_ff.offset} + HDR[32:0] == {1'b0, addr_ff}) begin
               if (!info_rd_ff.used) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOTALLOC;
                  state_in      = S_IDLE;
               end else begin
                  // Drop the used flag, then look at both neighbors.
                  info_we_used    = 1'b1;
                  info_wdata.used = 1'b0;
                  state_in        = S_R_P;
               end
            end else begin
               s_in     = rd_next;
               state_in = S_R_RD;
            end
         end
         S_R_P: begin
            rd_addr = cur_prev_ff[IW-1:0];
            if (cur_prev_ff < NULL_SLOT) begin
               rd_en    = 1'b1;
               state_in = S_R_PM;
            end else begin
               state_in = S_R_N;
            end
         end
         S_R_PM: begin
            if (!info_rd_ff.used) begin
               // Fold this block into the free predecessor.
               info_we_size    = 1'b1;
               info_waddr      = cur_prev_ff[IW-1:0];
               info_wdata.size = sum_size;
               link_we_next    = 1'b1;
               link_waddr      = cur_prev_ff[IW-1:0];
               link_wnext      = cur_next_ff;
               live_in[s_idx]  = 1'b0;
               cur_info_in     = '{offset: info_rd_ff.offset, size: sum_size,
                                   used: 1'b0};
               s_in            = cur_prev_ff;
               state_in        = (cur_next_ff < NULL_SLOT) ? S_R_PL : S_R_N;
            end else begin
               state_in = S_R_N;
            end
         end
         S_R_PL: begin
            link_we_prev = 1'b1;
            link_waddr   = cur_next_ff[IW-1:0];
            link_wprev   = s_ff;
            state_in     = S_R_N;
         end
         S_R_N: begin
            rd_addr = cur_next_ff[IW-1:0];
            if (cur_next_ff < NULL_SLOT) begin
               rd_en    = 1'b1;
               state_in = S_R_NM;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_R_NM: begin
            if (!info_rd_ff.used) begin
               // Absorb the free successor.
               info_we_size    = 1'b1;
               info_wdata.size = sum_size;
               link_we_next    = 1'b1;
               link_wnext      = rd_next;
               live_in[cur_next_ff[IW-1:0]] = 1'b0;
               after_in        = rd_next;
               if (rd_next < NULL_SLOT) begin
                  state_in = S_R_NL;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_R_NL: begin
            link_we_prev = 1'b1;
            link_waddr   = after_ff[IW-1:0];
            link_wprev   = s_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         heap_ff      <= HEAP_BYTES_RESET;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            heap_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      s_ff          <= s_in;
      cur_info_ff   <= cur_info_in;
      cur_next_ff   <= cur_next_in;
      cur_prev_ff   <= cur_prev_in;
      n_ff          <= n_in;
      after_ff      <= after_in;
      scan_ff       <= scan_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Header memories, registered read.
   always_ff @(posedge clock) begin
      if (info_we_off) begin
         info_mem[info_waddr].offset <= info_wdata.offset;
      end
      if (info_we_size) begin
         info_mem[info_waddr].size <= info_wdata.size;
      end
      if (info_we_used) begin
         info_mem[info_waddr].used <= info_wdata.used;
      end
      if (link_we_next) begin
         link_mem[link_waddr][2*SW-1:SW] <= link_wnext;
      end
      if (link_we_prev) begin
         link_mem[link_waddr][SW-1:0] <= link_wprev;
      end
      if (rd_en) begin
         info_rd_ff <= info_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   // The list head stays live outside of the boot cycle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_BOOT |-> live_ff[0])
      else $error("head slot lost");

   // A result only goes out as the block returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE)
      else $error("result while busy");

   // A granted address only comes with success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_grant_ff != '0 |-> rsp_status_ff == ST_OK)
      else $error("grant with failure status");

   // Memory is never written and read in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !(info_we_off || info_we_size || info_we_used ||
                  link_we_next || link_we_prev))
      else $error("read and write overlap");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit heap allocator: directed and random
// allocate / release / initialise transactions, checked against an in-bench
// model of the block list, with random start gaps and heap size changes.
// ----------------------------------------------------------------------------
module tb_top;
   import ffha_pkg::*;

   localparam int HDR    = HEADER_BYTES_DEF;
   localparam int NSLOT  = MAX_BLOCKS_DEF;
   localparam int LIMIT  = 4000000;

   // Scoreboard: carries the heap model and a queue of expected results.
   class heap_scoreboard;
      logic [31:0] heap_len;
      logic [31:0] offs [NSLOT];
      logic [31:0] sizes [NSLOT];
      bit          used [NSLOT];
      bit          live [NSLOT];
      int          nxt [NSLOT];
      int          prv [NSLOT];
      logic [31:0] exp_addr [$];
      status_type  exp_status [$];
      logic [31:0] grants [$];
      int          errors;

      function void heap_init();
         for (int i = 0; i < NSLOT; i++) begin
            offs[i] = 0; sizes[i] = 0; used[i] = 0; live[i] = 0;
            nxt[i] = NSLOT; prv[i] = NSLOT;
         end
         sizes[0] = heap_len;
         live[0] = 1;
         grants.delete();
      endfunction

      function status_type allocate(logic [31:0] req, output logic [31:0] addr);
         logic [63:0] need;
         logic [63:0] sz;
         int s, steps, n, after;
         need = 64'(req) + HDR;
         addr = 0;
         s = 0; steps = 0;
         if (req == 0) return ST_ZERO;
         while (s < NSLOT && live[s] && steps < NSLOT) begin
            steps++;
            if (!used[s]) begin
               sz = 64'(sizes[s]);
               if (sz > need && sz <= need + HDR) begin
                  used[s] = 1;
                  addr = offs[s] + HDR;
                  return ST_OK;
               end
               if (sz > need + HDR) begin
                  n = NSLOT;
                  for (int i = NSLOT - 1; i >= 0; i--) if (!live[i]) n = i;
                  if (n == NSLOT) return ST_FULL;
                  after = nxt[s];
                  live[n] = 1; used[n] = 0;
                  offs[n] = 32'(64'(offs[s]) + need);
                  sizes[n] = 32'(sz - need);
                  prv[n] = s; nxt[n] = after;
                  if (after < NSLOT) prv[after] = n;
                  nxt[s] = n;
                  sizes[s] = 32'(need);
                  used[s] = 1;
                  addr = offs[s] + HDR;
                  return ST_OK;
               end
            end
            s = nxt[s];
         end
         return ST_NOFIT;
      endfunction

      function status_type release_block(logic [31:0] a);
         int s, steps, p, n, after;
         s = 0; steps = 0;
         while (s < NSLOT && live[s] && steps < NSLOT) begin
            steps++;
            if (64'(offs[s]) + HDR == 64'(a)) break;
            s = nxt[s];
         end
         if (s >= NSLOT) return ST_NOTALLOC;
         if (!live[s] || !used[s] || 64'(offs[s]) + HDR != 64'(a)) return ST_NOTALLOC;
         used[s] = 0;
         p = prv[s];
         if (p < NSLOT && !used[p]) begin
            n = nxt[s];
            nxt[p] = n;
            if (n < NSLOT) prv[n] = p;
            sizes[p] = sizes[p] + sizes[s];
            live[s] = 0; nxt[s] = NSLOT; prv[s] = NSLOT;
            s = p;
         end
         n = nxt[s];
         if (n < NSLOT && !used[n]) begin
            after = nxt[n];
            sizes[s] = sizes[s] + sizes[n];
            nxt[s] = after;
            if (after < NSLOT) prv[after] = s;
            live[n] = 0; nxt[n] = NSLOT; prv[n] = NSLOT;
         end
         return ST_OK;
      endfunction

      // Note an accepted transaction and queue its expected result.
      function void note_request(opcode_type op, logic [31:0] req, logic [31:0] a);
         logic [31:0] addr;
         status_type  st;
         addr = 0;
         st = ST_OK;
         case (op)
            OP_ALLOC: begin
               st = allocate(req, addr);
               if (st == ST_OK) grants.push_back(addr);
            end
            OP_RELEASE: begin
               st = release_block(a);
               if (st == ST_OK)
                  foreach (grants[i]) if (grants[i] == a) begin
                     grants.delete(i);
                     break;
                  end
            end
            OP_INIT: heap_init();
            default: ;
         endcase
         exp_addr.push_back(addr);
         exp_status.push_back(st);
      endfunction

      // Compare one result with the oldest expectation.
      function void check_result(logic [31:0] addr, logic [2:0] st);
         if (exp_addr.size() == 0) begin
            $display("%0t: unexpected result addr=%h status=%0d", $time, addr, st);
            errors++;
            return;
         end
         if (addr !== exp_addr[0]) begin
            $display("%0t: granted_address expected %h actual %h",
                     $time, exp_addr[0], addr);
            errors++;
         end
         if (st !== exp_status[0]) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_status[0], st);
            errors++;
         end
         void'(exp_addr.pop_front());
         void'(exp_status.pop_front());
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_opcode = 0;
   logic [31:0] req_request_bytes = 0;
   logic [31:0] req_release_address = 0;
   logic        rsp_valid;
   logic [31:0] rsp_granted_address;
   logic [2:0]  rsp_status;
   logic        csr_wr_en = 0;
   logic [31:0] csr_wr_data = 0;

   heap_scoreboard sb;
   int cycles = 0;

   always #1 clock = ~clock;

   first_fit_heap_allocator u_dut (
      .clock, .reset, .start, .busy, .req_opcode, .req_request_bytes,
      .req_release_address, .rsp_valid, .rsp_granted_address, .rsp_status,
      .csr_wr_en, .csr_wr_data
   );

   // Sample results on the edge that accepts them.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_granted_address, rsp_status);
   end

   // Watchdog: end the run at a generous cycle count.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("first_fit_heap_allocator: mismatch");
         $finish;
      end
   end

   // Send one transaction: wait a random gap, raise start, hold until taken.
   // Start stays high after the accepting edge; a later call with a gap, or drain, drops it.
   task automatic send(opcode_type op, logic [31:0] req, logic [31:0] a, bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_opcode <= op;
      req_request_bytes <= req;
      req_release_address <= a;
      do @(posedge clock); while (busy);
      sb.note_request(op, req, a);
   endtask

   // Wait for every expected result, then let the block settle before a write.
   task automatic drain();
      start <= 0;
      while (sb.exp_addr.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_heap(logic [31:0] v);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.heap_len = v;
   endtask

   // Random transaction: mostly well-formed alloc/release pairs with noise.
   task automatic random_item(bit gaps);
      int pick;
      logic [31:0] req, a;
      pick = $urandom_range(0, 99);
      req = (pick % 4 == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 200);
      if (pick < 3) req = $urandom();
      a = $urandom();
      if (pick < 50) send(OP_ALLOC, req, a, gaps);
      else if (pick < 88 && sb.grants.size() != 0)
         send(OP_RELEASE, req, sb.grants[$urandom_range(0, sb.grants.size() - 1)], gaps);
      else if (pick < 94) send(OP_RELEASE, req, a, gaps);
      else if (pick < 97) send(OP_NOP, req, a, gaps);
      else send(OP_INIT, req, a, gaps);
   endtask

   initial begin
      logic [31:0] first;
      sb = new();
      sb.heap_len = HEAP_BYTES_RESET;
      sb.errors = 0;
      sb.heap_init();
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed: field extremes and special cases on the reset heap.
      send(OP_ALLOC, 0, 0);                 // zero size
      send(OP_ALLOC, 32'hFFFF_FFFF, 0);     // wide request, no fit
      send(OP_ALLOC, 32'hFFFF_FFE0, 0);
      send(OP_ALLOC, 1, 0);
      first = sb.grants.size() ? sb.grants[0] : 0;
      send(OP_ALLOC, 100, 32'hFFFF_FFFF);
      send(OP_RELEASE, 0, first);
      send(OP_RELEASE, 0, first);           // double release
      send(OP_RELEASE, 0, 32'hFFFF_FFFF);
      send(OP_RELEASE, 0, 0);
      send(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(OP_INIT, 32'hABAB_ABAB, 32'hCDCD_CDCD);
      // Exact-fit and one-header-over cases on a tiny heap.
      write_heap(64);
      send(OP_INIT, 0, 0);
      send(OP_ALLOC, 48, 0);                // no fit: needs more than 64
      send(OP_ALLOC, 40, 0);                // whole block, no split
      send(OP_RELEASE, 0, 16);
      send(OP_ALLOC, 16, 0);                // split
      send(OP_ALLOC, 8, 0);
      write_heap(17);                       // below range
      send(OP_INIT, 0, 0);
      send(OP_ALLOC, 1, 0);
      // Fill the slot table to reach table full on the largest heap.
      write_heap(32'hFFFF_FFFF);
      send(OP_INIT, 0, 0);
      for (int i = 0; i < NSLOT + 2; i++) send(OP_ALLOC, 1, 0, 0);
      send(OP_ALLOC, 32'hFFFF_FF00, 0);
      send(OP_INIT, 0, 0);

      // Random phases over several heap sizes.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_heap(HEAP_BYTES_RESET);
            1: write_heap(4096);
            2: write_heap($urandom());
            3: write_heap(32'hFFFF_FFFF);
            default: write_heap(64);
         endcase
         send(OP_INIT, 0, 0);
         for (int i = 0; i < 73; i++) random_item((i / 40) % 2 == 0);
      end

      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.exp_addr.size() == 0)
         $display("first_fit_heap_allocator: match");
      else
         $display("first_fit_heap_allocator: mismatch");
      $finish;
   end
endmodule
